/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/tekd_pkg.sv */
// Types and constants of the terminal escape key decoder.
package tekd_pkg;

	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_CLOSE = 2'd2;

	localparam logic [3:0] KK_PLAIN = 4'd0;
	localparam logic [3:0] KK_UP = 4'd1;
	localparam logic [3:0] KK_DOWN = 4'd2;
	localparam logic [3:0] KK_LEFT = 4'd3;
	localparam logic [3:0] KK_RIGHT = 4'd4;
	localparam logic [3:0] KK_HOME = 4'd5;
	localparam logic [3:0] KK_END = 4'd6;
	localparam logic [3:0] KK_DEL = 4'd7;
	localparam logic [3:0] KK_PGUP = 4'd8;
	localparam logic [3:0] KK_PGDN = 4'd9;
	localparam logic [3:0] KK_GONE = 4'd10;

	localparam logic [7:0] BYTE_IAC = 8'hFF;
	localparam logic [7:0] BYTE_ESC = 8'h1B;
	localparam logic [7:0] BYTE_CSI = 8'h5B;   // '['
	localparam logic [7:0] BYTE_SS3 = 8'h4F;   // 'O'
	localparam logic [7:0] BYTE_DIGIT0 = 8'h30;
	localparam logic [7:0] BYTE_DIGIT9 = 8'h39;
	localparam logic [7:0] BYTE_FIN_A = 8'h41;
	localparam logic [7:0] BYTE_FIN_B = 8'h42;
	localparam logic [7:0] BYTE_FIN_C = 8'h43;
	localparam logic [7:0] BYTE_FIN_D = 8'h44;
	localparam logic [7:0] BYTE_FIN_F = 8'h46;
	localparam logic [7:0] BYTE_FIN_H = 8'h48;

	localparam logic [1:0] IAC_SKIP = 2'd2;
	localparam logic [15:0] TIMEOUT_RESET = 16'd60;
	localparam logic [15:0] TICK_MAX = 16'hFFFF;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] kbyte;
		logic       last;
	} key_item_t;

	function automatic logic [3:0] digit_key(input logic [3:0] d);
		logic [3:0] k;
		case (d)
			4'd1, 4'd7: k = KK_HOME;
			4'd4, 4'd8: k = KK_END;
			4'd3:       k = KK_DEL;
			4'd5:       k = KK_PGUP;
			4'd6:       k = KK_PGDN;
			default:    k = KK_PLAIN;
		endcase
		return k;
	endfunction

	function automatic logic [3:0] final_key(input logic [7:0] b);
		logic [3:0] k;
		case (b)
			BYTE_FIN_A: k = KK_UP;
			BYTE_FIN_B: k = KK_DOWN;
			BYTE_FIN_C: k = KK_RIGHT;
			BYTE_FIN_D: k = KK_LEFT;
			BYTE_FIN_H: k = KK_HOME;
			BYTE_FIN_F: k = KK_END;
			default:    k = KK_PLAIN;
		endcase
		return k;
	endfunction

endpackage

/* design/tekd_in_if.sv */
// Input channel: received byte, tick or link-closed events.
interface tekd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink (input valid, input op, input rx_byte, output ready);
endinterface

/* design/tekd_out_if.sv */
// Output channel: decoded key events.
interface tekd_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] key_kind;
	logic [7:0] key_byte;
	logic       last_of_run;

	modport source (output valid, output key_kind, output key_byte, output last_of_run,
		input ready);
	modport sink (input valid, input key_kind, input key_byte, input last_of_run,
		output ready);
endinterface

/* design/terminal_escape_key_decoder.sv */
// Terminal escape key decoder: bytes, ticks and link-closed in, key events out.
//
// Each transaction on din is a received byte, one time tick or a link-closed
// event; each transaction on dout is one key event. The block takes one input
// transaction per cycle while din.ready is high: it lands in an input register,
// and once the result queue has room the decode state machine resolves it with
// a single pass of logic, and its zero, one or two key events go into a
// four-entry result queue that feeds dout. The queue drains one event per cycle
// while dout.ready is high, and the only input that yields more than one key
// event is a link-closed event during an open escape sequence, which yields
// the pending key followed by the disconnect event. din.ready drops only while
// the queue has fewer than two free entries. The escape timeout is set through
// cfg_we/cfg_wdata in ticks (reset value 60).
module terminal_escape_key_decoder
	import tekd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	tekd_in_if.sink       din,
	tekd_out_if.source    dout
);

	typedef enum logic [1:0] {PH_IDLE, PH_ESC, PH_BRACKET, PH_DIGIT} phase_t;

	logic [15:0]       timeout_q;
	logic              valid_s1;
	logic [1:0]        op_s1;
	logic [7:0]        byte_s1;

	phase_t            phase_q, phase_d;
	logic [1:0]        skip_q, skip_d;
	logic              untimed_q, untimed_d;
	logic [3:0]        digit_q, digit_d;
	logic [15:0]       ticks_q, ticks_d;

	key_item_t         queue_q [QDEPTH];
	logic [QPTR_W-1:0] rd_ptr_q, wr_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic              advance;
	logic              pop;
	logic [1:0]        n_res;
	key_item_t         res0, res1;
	logic [3:0]        pend_kind;
	logic [7:0]        pend_byte;
	logic [3:0]        fin_kind;
	logic [15:0]       ticks_inc;

	assign advance = valid_s1 && (count_q <= QCNT_W'(QDEPTH - 2));
	assign din.ready = !valid_s1 || advance;
	assign pop = dout.valid && dout.ready;

	assign dout.valid = (count_q != '0);
	assign dout.key_kind = queue_q[rd_ptr_q].kind;
	assign dout.key_byte = queue_q[rd_ptr_q].kbyte;
	assign dout.last_of_run = queue_q[rd_ptr_q].last;

	assign pend_kind = (phase_q == PH_DIGIT) ? digit_key(digit_q) : KK_PLAIN;
	assign pend_byte = (pend_kind == KK_PLAIN) ? BYTE_ESC : 8'd0;
	assign fin_kind = final_key(byte_s1);
	assign ticks_inc = (ticks_q != TICK_MAX) ? ticks_q + 16'd1 : ticks_q;

	always_comb begin
		phase_d = phase_q;
		skip_d = skip_q;
		untimed_d = untimed_q;
		digit_d = digit_q;
		ticks_d = ticks_q;
		n_res = 2'd0;
		res0 = '{kind: KK_PLAIN, kbyte: 8'd0, last: 1'b1};
		res1 = '{kind: KK_GONE, kbyte: 8'd0, last: 1'b1};
		case (op_s1)
			OP_BYTE: begin
				if (skip_q != 2'd0) begin
					skip_d = skip_q - 2'd1;
				end else if (byte_s1 == BYTE_IAC) begin
					skip_d = IAC_SKIP;
					if (phase_q != PH_IDLE) untimed_d = 1'b1;
				end else begin
					// default: sequence ends here with one key
					phase_d = PH_IDLE;
					untimed_d = 1'b0;
					ticks_d = 16'd0;
					n_res = 2'd1;
					case (phase_q)
						PH_IDLE: begin
							if (byte_s1 == BYTE_ESC) begin
								phase_d = PH_ESC;
								n_res = 2'd0;
							end else begin
								res0.kbyte = byte_s1;
							end
						end
						PH_ESC: begin
							if (byte_s1 == BYTE_CSI || byte_s1 == BYTE_SS3) begin
								phase_d = PH_BRACKET;
								n_res = 2'd0;
							end else begin
								res0.kbyte = BYTE_ESC;
							end
						end
						PH_BRACKET: begin
							if (byte_s1 >= BYTE_DIGIT0 && byte_s1 <= BYTE_DIGIT9) begin
								phase_d = PH_DIGIT;
								digit_d = byte_s1[3:0];
								n_res = 2'd0;
							end else begin
								res0.kind = fin_kind;
								res0.kbyte = (fin_kind == KK_PLAIN) ? BYTE_ESC : 8'd0;
							end
						end
						default: begin
							res0.kind = pend_kind;
							res0.kbyte = pend_byte;
						end
					endcase
				end
			end
			OP_TICK: begin
				if (phase_q != PH_IDLE && !untimed_q) begin
					if (ticks_inc < timeout_q) begin
						ticks_d = ticks_inc;
					end else begin
						phase_d = PH_IDLE;
						untimed_d = 1'b0;
						ticks_d = 16'd0;
						res0.kind = pend_kind;
						res0.kbyte = pend_byte;
						n_res = 2'd1;
					end
				end
			end
			OP_CLOSE: begin
				if (phase_q != PH_IDLE) begin
					res0.kind = pend_kind;
					res0.kbyte = pend_byte;
					res0.last = 1'b0;
					n_res = 2'd2;
				end else begin
					res0.kind = KK_GONE;
					n_res = 2'd1;
				end
				phase_d = PH_IDLE;
				skip_d = 2'd0;
				untimed_d = 1'b0;
				digit_d = 4'd0;
				ticks_d = 16'd0;
			end
			default: begin
				n_res = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			valid_s1 <= 1'b0;
			phase_q <= PH_IDLE;
			skip_q <= 2'd0;
			untimed_q <= 1'b0;
			digit_q <= 4'd0;
			ticks_q <= 16'd0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (cfg_we) timeout_q <= cfg_wdata;
			if (din.valid && din.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				phase_q <= phase_d;
				skip_q <= skip_d;
				untimed_q <= untimed_d;
				digit_q <= digit_d;
				ticks_q <= ticks_d;
				wr_ptr_q <= wr_ptr_q + QPTR_W'(n_res);
			end
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + (advance ? QCNT_W'(n_res) : QCNT_W'(0))
				- (pop ? QCNT_W'(1) : QCNT_W'(0));
		end
	end

	// input register and queue payload: no reset needed
	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			op_s1 <= din.op;
			byte_s1 <= din.rx_byte;
		end
		if (advance && n_res != 2'd0) queue_q[wr_ptr_q] <= res0;
		if (advance && n_res == 2'd2) queue_q[wr_ptr_q + QPTR_W'(1)] <= res1;
	end

endmodule

/* design/tekd_checker.sv */
// Port-level checker for the terminal escape key decoder, with its bind.
`include "assert_macros.svh"

module tekd_checker
	import tekd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] key_kind,
	input logic [7:0] key_byte,
	input logic       last_of_run
);

	`ASSERT_NEXT(a_valid_holds, clk, arst_n, out_valid && !out_ready, out_valid, "key event withdrawn while stalled")
	`ASSERT_IMPLIES(a_gone_last, clk, arst_n, out_valid && key_kind == KK_GONE, last_of_run, "disconnect not last of run")
	`ASSERT_IMPLIES(a_key_byte_zero, clk, arst_n, out_valid && key_kind != KK_PLAIN, key_byte == 8'd0, "special key carries a byte")
	`ASSERT_IMPLIES(a_kind_range, clk, arst_n, out_valid, key_kind <= KK_GONE, "key kind out of range")

endmodule

bind terminal_escape_key_decoder tekd_checker u_tekd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(dout.valid),
	.out_ready(dout.ready),
	.key_kind(dout.key_kind),
	.key_byte(dout.key_byte),
	.last_of_run(dout.last_of_run)
);

/* tb/terminal_escape_key_decoder_tb.sv */
// Self-checking testbench for the terminal escape key decoder.
module terminal_escape_key_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tekd_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [7:0] BYTE_TILDE = 8'h7E;

	typedef enum logic [1:0] {SEQ_IDLE, SEQ_ESC, SEQ_BRACKET, SEQ_DIGIT} seq_phase_t;

	class key_scoreboard;
		logic [15:0] timeout_ticks;
		seq_phase_t  phase;
		logic [1:0]  skip_left;
		logic        untimed;
		logic [3:0]  held_digit;
		logic [15:0] tick_count;
		key_item_t   expected_keys[$];
		int          errors;

		function new();
			timeout_ticks = TIMEOUT_RESET;
			errors = 0;
			clear_state();
		endfunction

		function void clear_state();
			phase = SEQ_IDLE;
			skip_left = 2'd0;
			untimed = 1'b0;
			held_digit = 4'd0;
			tick_count = 16'd0;
		endfunction

		function void open_wait(seq_phase_t p);
			phase = p;
			tick_count = 16'd0;
			untimed = 1'b0;
		endfunction

		function void close_wait();
			phase = SEQ_IDLE;
			untimed = 1'b0;
			tick_count = 16'd0;
		endfunction

		function key_item_t make_key(logic [3:0] kind, logic [7:0] kbyte);
			key_item_t k;
			k.kind = kind;
			k.kbyte = kbyte;
			k.last = 1'b0;
			return k;
		endfunction

		// Key for a sequence that ends without its next byte.
		function key_item_t pending_key();
			logic [3:0] kind;
			kind = KK_PLAIN;
			if (phase == SEQ_DIGIT) begin
				case (held_digit)
					4'd1, 4'd7: kind = KK_HOME;
					4'd4, 4'd8: kind = KK_END;
					4'd3: kind = KK_DEL;
					4'd5: kind = KK_PGUP;
					4'd6: kind = KK_PGDN;
					default: kind = KK_PLAIN;
				endcase
			end
			return make_key(kind, (kind == KK_PLAIN) ? BYTE_ESC : 8'h00);
		endfunction

		function key_item_t final_byte_key(logic [7:0] b);
			case (b)
				BYTE_FIN_A: return make_key(KK_UP, 8'h00);
				BYTE_FIN_B: return make_key(KK_DOWN, 8'h00);
				BYTE_FIN_C: return make_key(KK_RIGHT, 8'h00);
				BYTE_FIN_D: return make_key(KK_LEFT, 8'h00);
				BYTE_FIN_H: return make_key(KK_HOME, 8'h00);
				BYTE_FIN_F: return make_key(KK_END, 8'h00);
				default: return make_key(KK_PLAIN, BYTE_ESC);
			endcase
		endfunction

		// Advance the decoder by one accepted transaction and queue its keys.
		function void decode_input(logic [1:0] op, logic [7:0] b);
			key_item_t run[$];
			case (op)
				OP_BYTE: begin
					if (skip_left != 2'd0) begin
						skip_left--;
						return;
					end
					if (b == BYTE_IAC) begin
						skip_left = IAC_SKIP;
						if (phase != SEQ_IDLE)
							untimed = 1'b1;
						return;
					end
					case (phase)
						SEQ_IDLE: begin
							if (b == BYTE_ESC) begin
								open_wait(SEQ_ESC);
								return;
							end
							run.push_back(make_key(KK_PLAIN, b));
						end
						SEQ_ESC: begin
							if (b == BYTE_CSI || b == BYTE_SS3) begin
								open_wait(SEQ_BRACKET);
								return;
							end
							run.push_back(make_key(KK_PLAIN, BYTE_ESC));
						end
						SEQ_BRACKET: begin
							if (b >= BYTE_DIGIT0 && b <= BYTE_DIGIT9) begin
								held_digit = 4'(b - BYTE_DIGIT0);
								open_wait(SEQ_DIGIT);
								return;
							end
							run.push_back(final_byte_key(b));
						end
						default: run.push_back(pending_key());
					endcase
					close_wait();
				end
				OP_TICK: begin
					if (phase == SEQ_IDLE || untimed)
						return;
					if (tick_count != TICK_MAX)
						tick_count++;
					if (tick_count < timeout_ticks)
						return;
					run.push_back(pending_key());
					close_wait();
				end
				OP_CLOSE: begin
					if (phase != SEQ_IDLE)
						run.push_back(pending_key());
					run.push_back(make_key(KK_GONE, 8'h00));
					clear_state();
				end
				default: return;
			endcase
			run[run.size() - 1].last = 1'b1;
			foreach (run[i])
				expected_keys.push_back(run[i]);
		endfunction

		function void check_key(logic [3:0] kind, logic [7:0] kbyte, logic last);
			key_item_t want;
			if (expected_keys.size() == 0) begin
				$display("%0t: unexpected key event kind %0d byte %02h last %0b",
					$time, kind, kbyte, last);
				errors++;
				return;
			end
			want = expected_keys.pop_front();
			if (kind !== want.kind || kbyte !== want.kbyte || last !== want.last) begin
				$display("%0t: expected kind %0d byte %02h last %0b, got %0d %02h %0b",
					$time, want.kind, want.kbyte, want.last, kind, kbyte, last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_keys.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	tekd_in_if  din_if();
	tekd_out_if dout_if();

	terminal_escape_key_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.din      (din_if),
		.dout     (dout_if)
	);

	key_scoreboard board = new();
	int src_gap_pct = 0;
	int sink_stall_pct = 0;
	int items_sent = 0;

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("terminal_escape_key_decoder test failed");
		$finish;
	end

	// Key event receiver: sample at the rising edge, stall at random.
	initial begin
		dout_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && dout_if.valid && dout_if.ready)
				board.check_key(dout_if.key_kind, dout_if.key_byte, dout_if.last_of_run);
			@(negedge clk);
			dout_if.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic send_event(logic [1:0] op, logic [7:0] b);
		while ($urandom_range(99) < src_gap_pct) begin
			din_if.valid <= 1'b0;
			@(negedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.op <= op;
		din_if.rx_byte <= b;
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
		board.decode_input(op, b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_iac();
		send_event(OP_BYTE, BYTE_IAC);
		send_event(OP_BYTE, 8'($urandom_range(255)));
		send_event(OP_BYTE, 8'($urandom_range(255)));
	endtask

	// Now and then slip a telnet command in front of the byte.
	task automatic send_byte(logic [7:0] b);
		if ($urandom_range(49) == 0)
			send_iac();
		send_event(OP_BYTE, b);
	endtask

	task automatic send_ticks(int n);
		repeat (n)
			send_event(OP_TICK, 8'($urandom_range(255)));
	endtask

	task automatic hold_until_drained();
		din_if.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_escape_timeout(logic [15:0] v);
		hold_until_drained();
		// let transactions that make no key finish before the write
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.timeout_ticks = v;
	endtask

	function automatic logic [7:0] pick_final();
		case ($urandom_range(5))
			0: return BYTE_FIN_A;
			1: return BYTE_FIN_B;
			2: return BYTE_FIN_C;
			3: return BYTE_FIN_D;
			4: return BYTE_FIN_H;
			default: return BYTE_FIN_F;
		endcase
	endfunction

	// Land just short of, on, or just past the timeout; above 64, anywhere in 1 to 64.
	function automatic int ticks_near_timeout();
		int n;
		if (board.timeout_ticks > 16'd64)
			return $urandom_range(1, 64);
		n = int'(board.timeout_ticks) + int'($urandom_range(2)) - 1;
		return (n < 1) ? 1 : n;
	endfunction

	task automatic send_random_sequence();
		int pick;
		logic [7:0] lead;
		pick = $urandom_range(99);
		lead = $urandom_range(1) ? BYTE_CSI : BYTE_SS3;
		if (pick < 18) begin
			send_byte(8'($urandom_range(255)));
		end else if (pick < 42) begin
			send_byte(BYTE_ESC);
			send_byte(lead);
			send_byte(($urandom_range(4) != 0) ? pick_final() : 8'($urandom_range(255)));
		end else if (pick < 58) begin
			send_byte(BYTE_ESC);
			send_byte(lead);
			send_byte(BYTE_DIGIT0 + 8'($urandom_range(9)));
			case ($urandom_range(3))
				0: send_ticks(ticks_near_timeout());
				1: send_byte(8'($urandom_range(255)));
				default: send_byte(BYTE_TILDE);
			endcase
		end else if (pick < 68) begin
			send_byte(BYTE_ESC);
			if ($urandom_range(1))
				send_byte(lead);
			send_ticks(ticks_near_timeout());
			if ($urandom_range(1))
				send_byte(pick_final());
		end else if (pick < 78) begin
			// telnet command inside a wait: ticks stop counting
			send_byte(BYTE_ESC);
			if ($urandom_range(1))
				send_byte(lead);
			send_iac();
			send_ticks($urandom_range(4));
			if ($urandom_range(1))
				send_event(OP_CLOSE, 8'($urandom_range(255)));
			else
				send_byte(pick_final());
		end else if (pick < 86) begin
			if ($urandom_range(1))
				send_byte(BYTE_ESC);
			if ($urandom_range(1))
				send_byte(lead);
			if ($urandom_range(1))
				send_byte(BYTE_DIGIT0 + 8'($urandom_range(9)));
			send_event(OP_CLOSE, 8'($urandom_range(255)));
		end else if (pick < 93) begin
			send_event($urandom_range(1) ? OP_TICK : OP_UNUSED, 8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 4))
				send_event(2'($urandom_range(3)), 8'($urandom_range(255)));
		end
	endtask

	task automatic run_random(int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at)
			send_random_sequence();
	endtask

	task automatic run_directed();
		send_event(OP_BYTE, 8'h00);
		send_event(OP_BYTE, BYTE_ESC);
		send_event(OP_BYTE, BYTE_CSI);
		send_event(OP_BYTE, BYTE_FIN_A);
		send_event(OP_BYTE, BYTE_ESC);
		send_event(OP_BYTE, BYTE_SS3);
		send_event(OP_BYTE, BYTE_DIGIT0 + 8'd7);
		send_event(OP_BYTE, BYTE_TILDE);
		// unknown final byte
		send_event(OP_BYTE, BYTE_ESC);
		send_event(OP_BYTE, BYTE_CSI);
		send_event(OP_BYTE, 8'h5A);
		// non-bracket byte after ESC is swallowed
		send_event(OP_BYTE, BYTE_ESC);
		send_event(OP_BYTE, 8'h71);
		// unknown digit
		send_event(OP_BYTE, BYTE_ESC);
		send_event(OP_BYTE, BYTE_CSI);
		send_event(OP_BYTE, BYTE_DIGIT0);
		send_event(OP_BYTE, BYTE_TILDE);
		// timeout in place of the byte after the digit
		send_event(OP_BYTE, BYTE_ESC);
		send_event(OP_BYTE, BYTE_CSI);
		send_event(OP_BYTE, BYTE_DIGIT0 + 8'd6);
		send_ticks(2);
		// telnet command makes the wait untimed, then the link closes
		send_event(OP_BYTE, BYTE_ESC);
		send_event(OP_BYTE, BYTE_IAC);
		send_event(OP_BYTE, 8'hFB);
		send_event(OP_BYTE, BYTE_ESC);
		send_ticks(3);
		send_event(OP_CLOSE, 8'h00);
		send_event(OP_UNUSED, 8'hFF);
		send_event(OP_TICK, 8'h00);
		send_event(OP_CLOSE, 8'h00);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 16'd0;
		din_if.valid = 1'b0;
		din_if.op = OP_BYTE;
		din_if.rx_byte = 8'h00;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_gap_pct = 9;
		sink_stall_pct = 48;
		// reset timeout: one tick short still decodes, a full wait gives ESC
		send_event(OP_BYTE, BYTE_ESC);
		send_event(OP_BYTE, BYTE_CSI);
		send_ticks(int'(TIMEOUT_RESET) - 1);
		send_event(OP_BYTE, BYTE_FIN_B);
		send_event(OP_BYTE, BYTE_ESC);
		send_ticks(int'(TIMEOUT_RESET));
		set_escape_timeout(16'd2);
		run_directed();
		set_escape_timeout(16'd3);
		run_random(50);

		src_gap_pct = 48;
		sink_stall_pct = 9;
		set_escape_timeout(16'd0);
		run_random(40);
		hold_until_drained();
		run_random(30);
		set_escape_timeout(16'd1);
		run_random(40);

		src_gap_pct = 0;
		sink_stall_pct = 0;
		set_escape_timeout(16'hFFFF);
		send_event(OP_BYTE, BYTE_ESC);
		send_event(OP_BYTE, BYTE_CSI);
		send_event(OP_BYTE, BYTE_DIGIT0 + 8'd4);
		send_ticks(40);
		run_random(30);
		set_escape_timeout(16'($urandom_range(2, 20)));
		run_random(60);

		hold_until_drained();
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("terminal_escape_key_decoder test passed");
		else
			$display("terminal_escape_key_decoder test failed");
		$finish;
	end
endmodule
